// ===== rtl/plpr_pkg.sv =====
// Shared types and codes for the powerline interface poll responder.
package plpr_pkg;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_MASK    = 2'd1,
		PH_DATA    = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_REPLY = 2'd0,
		KIND_ADDR  = 2'd1,
		KIND_FUNC  = 2'd2,
		KIND_SYNC  = 2'd3
	} kind_t;

	localparam logic [7:0] CODE_NULL  = 8'h00;
	localparam logic [7:0] CODE_POLL  = 8'h5A;
	localparam logic [7:0] CODE_TIME  = 8'hA5;
	localparam logic [7:0] CODE_READY = 8'h55;
	localparam logic [7:0] REPLY_POLL = 8'hC3;
	localparam logic [7:0] REPLY_TIME = 8'h9B;
	localparam logic [7:0] MAX_LEN    = 8'd9;
	localparam logic [3:0] DISCARD_COUNT = 4'd10;
	// zero bytes that follow the time reply header
	localparam logic [2:0] TIME_TAIL  = 3'd6;

endpackage

// ===== rtl/powerline_interface_poll_responder.sv =====
// Poll responder: answers bytes from a powerline controller interface.
//
// Usage: bytes arrive on the input channel (in_valid/in_ready, rx_byte); results
// leave on the output channel (out_valid/out_ready, kind, value, last). Each
// request may cause zero, one or seven results; last marks the final one.
// An accepted byte is captured in an input register, the decode runs against
// the protocol state, and the result register is loaded from the decode once
// the output side is free. Throughput is one byte per cycle, but a byte that
// causes a result waits while the output side is busy; bytes causing no
// result never wait for the output side. A time request holds the result
// register for its seven results, counted down by a small burst counter; new
// bytes that cause a result wait meanwhile. When the receiver stalls, the
// result register holds and the input register still takes one more byte
// before in_ready drops.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// protocol state to idle with no packet or discard in progress.
module powerline_interface_poll_responder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           kind,
	output logic [7:0]           value,
	output logic                 last
);
	import plpr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [3:0]  bytes_left_q, bytes_left_d;
	logic [7:0]  type_mask_q, type_mask_d;
	logic [2:0]  mask_bit_q, mask_bit_d;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  value_q;
	logic        last_q;
	logic [2:0]  burst_q;

	logic        emit;
	logic        burst;
	kind_t       emit_kind;
	logic [7:0]  emit_value;
	logic        out_free;
	logic        advance;
	logic [3:0]  left_dec;

	assign out_free = !out_valid_q || (out_ready && burst_q == 3'd0);
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;
	assign left_dec = bytes_left_q - 4'd1;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		type_mask_d  = type_mask_q;
		mask_bit_d   = mask_bit_q;
		emit         = 1'b0;
		burst        = 1'b0;
		emit_kind    = KIND_REPLY;
		emit_value   = byte_s1;
		case (phase_q)
			PH_MASK: begin
				type_mask_d  = byte_s1;
				mask_bit_d   = 3'd0;
				bytes_left_d = left_dec;
				phase_d      = (left_dec == 4'd0) ? PH_IDLE : PH_DATA;
			end
			PH_DATA: begin
				emit         = 1'b1;
				emit_kind    = type_mask_q[mask_bit_q] ? KIND_FUNC : KIND_ADDR;
				mask_bit_d   = mask_bit_q + 3'd1;
				bytes_left_d = left_dec;
				if (left_dec == 4'd0)
					phase_d = PH_IDLE;
			end
			PH_DISCARD: begin
				bytes_left_d = left_dec;
				if (left_dec == 4'd0)
					phase_d = PH_IDLE;
			end
			default: begin
				if (byte_s1 == CODE_POLL) begin
					emit       = 1'b1;
					emit_value = REPLY_POLL;
				end else if (byte_s1 == CODE_NULL) begin
					emit       = 1'b1;
					emit_value = CODE_NULL;
				end else if (byte_s1 == CODE_TIME) begin
					emit       = 1'b1;
					burst      = 1'b1;
					emit_value = REPLY_TIME;
				end else if (byte_s1 == CODE_READY) begin
					emit = 1'b0;
				end else if (byte_s1 > MAX_LEN) begin
					emit         = 1'b1;
					emit_kind    = KIND_SYNC;
					emit_value   = 8'h00;
					bytes_left_d = DISCARD_COUNT;
					phase_d      = PH_DISCARD;
				end else begin
					bytes_left_d = byte_s1[3:0];
					phase_d      = PH_MASK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bytes_left_q <= 4'd0;
			type_mask_q  <= 8'h00;
			mask_bit_q   <= 3'd0;
		end else if (advance) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			type_mask_q  <= type_mask_d;
			mask_bit_q   <= mask_bit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q     <= 3'd0;
		end else if (out_valid_q && out_ready && burst_q != 3'd0) begin
			burst_q <= burst_q - 3'd1;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
			burst_q     <= (advance && burst) ? TIME_TAIL : 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready && burst_q != 3'd0) begin
			// zero tail of the time reply
			kind_q  <= KIND_REPLY;
			value_q <= 8'h00;
			last_q  <= (burst_q == 3'd1);
		end else if (out_free && advance && emit) begin
			kind_q  <= emit_kind;
			value_q <= emit_value;
			last_q  <= !burst;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

	a_burst_holds_valid: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q != 3'd0 |-> out_valid_q && !last_q)
		else $error("burst in progress without a pending non-final result");

	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bytes_left_q == 4'd0)
		else $error("idle with bytes still expected");

	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA || phase_q == PH_DISCARD |-> bytes_left_q != 4'd0)
		else $error("packet or discard phase with zero count");

	a_sync_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_SYNC |-> value_q == 8'h00 && last_q)
		else $error("sync error result malformed");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && !out_free |=> valid_s1 && $stable(byte_s1))
		else $error("request dropped while output busy");

endmodule
